// ===== rtl/core/row_major_address_generator_top_macros.svh =====
// Assertion macros shared by the address generator RTL.
`ifndef ROW_MAJOR_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define ROW_MAJOR_ADDRESS_GENERATOR_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define RMAG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RMAG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rmag_pkg.sv =====
// Shared types and constants for the row-major address generator.
package rmag_pkg;

  localparam int MAX_DIMS = 16;
  localparam int DATA_W   = 32;
  localparam int ES_W     = 16;
  localparam int DC_W     = 5;
  localparam int SEL_W    = 4;
  localparam int POS_W    = 5;
  localparam int IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CMP_W    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 2;
  localparam int PADDR_W  = 4;
  localparam int REG_W    = 2;

  localparam logic [REG_W-1:0] REG_BASE_ADDRESS    = REG_W'(0);
  localparam logic [REG_W-1:0] REG_ELEMENT_SIZE    = REG_W'(1);
  localparam logic [REG_W-1:0] REG_DIMENSION_COUNT = REG_W'(2);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SUB  = 1'b1
  } rmag_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SCALE,
    S_OUT
  } rmag_state_t;

  typedef struct packed {
    logic mul_en;
    logic mul_scale;
    logic diff_en;
    logic acc_update;
    logic out_load;
  } rmag_ctrl_t;

endpackage

// ===== rtl/core/rmag_bound_table.sv =====
// Bound table: lower bound and length per dimension, registered read.
module rmag_bound_table
  import rmag_pkg::*;
(
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic signed [DATA_W-1:0] lower_bound,
  input  logic signed [DATA_W-1:0] upper_bound,
  input  logic                     re,
  input  logic [IDX_W-1:0]         rd_idx,
  output logic [DATA_W-1:0]        lower_rd,
  output logic [DATA_W-1:0]        length_rd
);

  logic [DATA_W-1:0] lower_mem  [MAX_DIMS];
  logic [DATA_W-1:0] length_mem [MAX_DIMS];
  logic [DATA_W-1:0] length_wr;

  // Length wraps at the data width
  assign length_wr = DATA_W'(upper_bound) - DATA_W'(lower_bound) + DATA_W'(1);

  // Write one dimension's bounds
  always_ff @(posedge clk) begin
    if (we) begin
      lower_mem[wr_idx]  <= DATA_W'(lower_bound);
      length_mem[wr_idx] <= length_wr;
    end
  end

  // Read the current dimension into the output register
  always_ff @(posedge clk) begin
    if (re) begin
      lower_rd  <= lower_mem[rd_idx];
      length_rd <= length_mem[rd_idx];
    end
  end

endmodule

// ===== rtl/core/rmag_mul.sv =====
// Shared multiplier: low product bits, registered.
module rmag_mul
  import rmag_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] product
);

  logic [DATA_W-1:0] full;

  assign full = a * b;

  // Keep the wrapped product
  always_ff @(posedge clk) begin
    if (en) begin
      product <= full;
    end
  end

endmodule

// ===== rtl/core/rmag_ctrl.sv =====
// Sequencer: dimension position, last-dimension decision and step control.
`include "row_major_address_generator_top_macros.svh"

module rmag_ctrl
  import rmag_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             opcode,
  input  logic [DC_W-1:0]  dimension_count,
  output logic             busy,
  output logic             sub_take,
  output logic [IDX_W-1:0] rd_idx,
  output rmag_ctrl_t       ctrl
);

  rmag_state_t      state;
  rmag_state_t      state_next;
  logic [POS_W-1:0] dim_position;
  logic [POS_W-1:0] dim_position_next;
  logic             last;
  logic             last_next;
  logic [CMP_W-1:0] pos_eff;
  logic [CMP_W-1:0] dims_eff;

  // Accept a subscript beat only when idle
  assign sub_take = start && (state == S_IDLE) && (opcode == OP_SUB);

  // Clamp the position and the dimension count to the table depth; a zero count acts as one
  always_comb begin
    if (CMP_W'(dim_position) > CMP_W'(MAX_DIMS - 1)) begin
      pos_eff = CMP_W'(MAX_DIMS - 1);
    end else begin
      pos_eff = CMP_W'(dim_position);
    end
    if (dimension_count == '0) begin
      dims_eff = CMP_W'(1);
    end else if (CMP_W'(dimension_count) > CMP_W'(MAX_DIMS)) begin
      dims_eff = CMP_W'(MAX_DIMS);
    end else begin
      dims_eff = CMP_W'(dimension_count);
    end
  end

  assign rd_idx = pos_eff[IDX_W-1:0];

  // Advance or wrap the position at each subscript beat
  always_comb begin
    dim_position_next = dim_position;
    last_next         = last;
    if (sub_take) begin
      last_next = (pos_eff + CMP_W'(1)) >= dims_eff;
      if (last_next) begin
        dim_position_next = '0;
      end else begin
        dim_position_next = POS_W'(pos_eff + CMP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dim_position <= '0;
      last         <= 1'b0;
    end else begin
      state        <= state_next;
      dim_position <= dim_position_next;
      last         <= last_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sub_take) state_next = S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = last ? S_SCALE : S_IDLE;
      S_SCALE: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Step outputs
  always_comb begin
    busy = 1'b1;
    ctrl = '0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_MUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.diff_en = 1'b1;
      end
      S_ADD: begin
        ctrl.acc_update = 1'b1;
      end
      S_SCALE: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_scale = 1'b1;
      end
      S_OUT: begin
        ctrl.out_load = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `RMAG_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && dim_position == '0), "reset left sequencer active")
  `RMAG_ASSERT(a_scale_then_out, (state == S_SCALE) |=> (state == S_OUT), "scale step not followed by output step")
  `RMAG_ASSERT(a_pos_cleared_on_out, (state == S_OUT) |-> (dim_position == '0), "position not cleared for finished address")
  `RMAG_ASSERT(a_take_starts_mul, sub_take |=> (state == S_MUL && busy), "subscript beat did not start the multiply step")

endmodule

// ===== rtl/core/row_major_address_generator_top.sv =====
// Top level of the row-major address generator.
//
// Usage:
//   Items enter on start while busy is low. opcode OP_LOAD writes the bounds
//   of dimension dim_select into the bound table and gives no result; a
//   dim_select beyond the table is dropped. opcode OP_SUB supplies the
//   subscript for the next dimension; busy rises for the multiply-add.
//   A subscript that is not the last one holds busy through the multiply
//   and add steps. The last subscript of an address goes through the
//   multiply-add, then the element size multiply, then the base add. address
//   is shown with done for exactly one cycle; the receiver cannot stall, so
//   the result never waits. The single shared 32x32 multiplier is used once
//   per subscript and once per address.
//   Configuration goes through the APB port: base_address at 0x0,
//   element_size at 0x4, dimension_count at 0x8; write only while idle.
//   Reset clears the accumulator, the position, the strobe and the registers
//   to their defaults; the bound table holds junk until loaded.
module row_major_address_generator_top
  import rmag_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode,
  input  logic [SEL_W-1:0]         dim_select,
  input  logic signed [DATA_W-1:0] lower_bound,
  input  logic signed [DATA_W-1:0] upper_bound,
  input  logic signed [DATA_W-1:0] subscript,
  // result channel
  output logic                     done,
  output logic signed [DATA_W-1:0] address,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  `include "row_major_address_generator_top_macros.svh"

  logic [DATA_W-1:0] base_address;
  logic [ES_W-1:0]   element_size;
  logic [DC_W-1:0]   dimension_count;
  logic [REG_W-1:0]  reg_idx;
  logic              cfg_we;

  logic              sub_take;
  logic              load_take;
  logic [CMP_W-1:0]  sel_ext;
  logic              tbl_we;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] lower_rd;
  logic [DATA_W-1:0] length_rd;
  rmag_ctrl_t        ctrl;

  logic [DATA_W-1:0] sub_q;
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] product;

  // Register file writes
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= '0;
      element_size    <= ES_W'(1);
      dimension_count <= DC_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_BASE_ADDRESS:    base_address    <= pwdata[DATA_W-1:0];
        REG_ELEMENT_SIZE:    element_size    <= pwdata[ES_W-1:0];
        REG_DIMENSION_COUNT: dimension_count <= pwdata[DC_W-1:0];
        default:             ;
      endcase
    end
  end

  // Register file reads
  always_comb begin
    unique case (reg_idx)
      REG_BASE_ADDRESS:    prdata = base_address;
      REG_ELEMENT_SIZE:    prdata = 32'(element_size);
      REG_DIMENSION_COUNT: prdata = 32'(dimension_count);
      default:             prdata = '0;
    endcase
  end

  // Drop loads aimed past the table
  assign load_take = start && !busy && (opcode == OP_LOAD);
  assign sel_ext   = CMP_W'(dim_select);
  assign tbl_we    = load_take && (sel_ext < CMP_W'(MAX_DIMS));

  rmag_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .opcode          (opcode),
    .dimension_count (dimension_count),
    .busy            (busy),
    .sub_take        (sub_take),
    .rd_idx          (rd_idx),
    .ctrl            (ctrl)
  );

  rmag_bound_table u_table (
    .clk         (clk),
    .we          (tbl_we),
    .wr_idx      (sel_ext[IDX_W-1:0]),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .re          (sub_take),
    .rd_idx      (rd_idx),
    .lower_rd    (lower_rd),
    .length_rd   (length_rd)
  );

  // Select multiplier operands: accumulate or scale by element size
  assign mul_a = ctrl.mul_scale ? DATA_W'(element_size) : acc;
  assign mul_b = ctrl.mul_scale ? acc : length_rd;

  rmag_mul u_mul (
    .clk     (clk),
    .en      (ctrl.mul_en),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  // Hold the subscript and form its offset within the dimension
  always_ff @(posedge clk) begin
    if (sub_take) begin
      sub_q <= DATA_W'(subscript);
    end
    if (ctrl.diff_en) begin
      diff <= sub_q - lower_rd;
    end
  end

  // Accumulate, clear once the address is out
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.acc_update) begin
      acc <= product + diff;
    end else if (ctrl.out_load) begin
      acc <= '0;
    end
  end

  // Drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      address <= base_address + product;
    end
  end

  `RMAG_ASSERT(a_done_one_cycle, done |=> !done, "result strobe held longer than one cycle")
  `RMAG_ASSERT(a_acc_clear_on_done, done |-> (acc == '0), "accumulator not cleared after result")
  `RMAG_ASSERT(a_done_when_idle, done |-> !busy, "result shown while busy")
  `RMAG_ASSERT(a_no_load_in_work, tbl_we |-> !ctrl.mul_en && !ctrl.acc_update, "table load during computation")

endmodule

// ===== tb/row_major_address_generator_checker.sv =====
// Checker for the address generator: tracks bounds and accumulator, predicts and compares addresses.
`timescale 1ns / 100ps

module row_major_address_generator_checker
  import rmag_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     opcode,
  input  logic [SEL_W-1:0]         dim_select,
  input  logic signed [DATA_W-1:0] lower_bound,
  input  logic signed [DATA_W-1:0] upper_bound,
  input  logic signed [DATA_W-1:0] subscript,
  input  logic                     done,
  input  logic signed [DATA_W-1:0] address,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  output int                       fail_count,
  output int                       pending
);

  // Mirror of the configuration registers
  bit [DATA_W-1:0] base_mirror;
  bit [ES_W-1:0]   esize_mirror;
  bit [DC_W-1:0]   dcount_mirror;

  // Mirror of the bound table and the running offset
  bit [DATA_W-1:0] lower_mirror [MAX_DIMS];
  bit [DATA_W-1:0] length_mirror [MAX_DIMS];
  bit [DATA_W-1:0] offset_mirror;
  bit [POS_W-1:0]  position_mirror;

  bit [DATA_W-1:0] expected_addresses [$];
  int              mismatches = 0;

  // Fold one subscript into the offset; queue an address when the last dimension is in
  task automatic fold_subscript(input bit [DATA_W-1:0] sub);
    int              slot;
    int              dims;
    bit [DATA_W-1:0] esize_wide;
    bit [DATA_W-1:0] expected_addr;
    slot = (position_mirror >= MAX_DIMS) ? MAX_DIMS - 1 : int'(position_mirror);
    dims = (dcount_mirror == 0) ? 1 :
           (dcount_mirror > MAX_DIMS) ? MAX_DIMS : int'(dcount_mirror);
    offset_mirror = offset_mirror * length_mirror[slot] + (sub - lower_mirror[slot]);
    if (slot + 1 >= dims) begin
      esize_wide         = DATA_W'(esize_mirror);
      expected_addr      = base_mirror + esize_wide * offset_mirror;
      expected_addresses = {expected_addresses, expected_addr};
      offset_mirror      = '0;
      position_mirror    = '0;
    end else begin
      position_mirror = POS_W'(slot + 1);
    end
  endtask

  always @(posedge clk) begin
    bit [DATA_W-1:0] want;
    if (rst) begin
      base_mirror     = '0;
      esize_mirror    = ES_W'(1);
      dcount_mirror   = DC_W'(1);
      offset_mirror   = '0;
      position_mirror = '0;
      expected_addresses.delete();
    end else begin
      // Compare a result beat against the oldest expectation
      if (done === 1'b1) begin
        if (expected_addresses.size() == 0) begin
          $error("address: no result expected, got %h", address);
          mismatches++;
        end else begin
          want = expected_addresses.pop_front();
          if (address !== want) begin
            $error("address: expected %h, got %h", want, address);
            mismatches++;
          end
        end
      end

      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_BASE_ADDRESS:    base_mirror   = pwdata[DATA_W-1:0];
          REG_ELEMENT_SIZE:    esize_mirror  = pwdata[ES_W-1:0];
          REG_DIMENSION_COUNT: dcount_mirror = pwdata[DC_W-1:0];
          default: ;
        endcase
      end

      // Predict on every accepted item beat
      if (start && !busy) begin
        if (opcode == OP_LOAD) begin
          lower_mirror[dim_select]  = lower_bound;
          length_mirror[dim_select] = upper_bound - lower_bound + 1;
        end else begin
          fold_subscript(subscript);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_addresses.size();
  end

endmodule

// ===== tb/row_major_address_generator_top_test.sv =====
// Testbench top for the address generator: drives items and register writes, gives the verdict.
`timescale 1ns / 100ps

module row_major_address_generator_top_test;
  import rmag_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     opcode = OP_LOAD;
  logic [SEL_W-1:0]         dim_select = '0;
  logic signed [DATA_W-1:0] lower_bound = '0;
  logic signed [DATA_W-1:0] upper_bound = '0;
  logic signed [DATA_W-1:0] subscript = '0;
  logic                     done;
  logic signed [DATA_W-1:0] address;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  int                       fail_count;
  int                       pending;

  // Bounds as loaded, used to aim subscripts inside their range
  bit [DATA_W-1:0] lower_loaded [MAX_DIMS];
  bit [DATA_W-1:0] length_loaded [MAX_DIMS];

  row_major_address_generator_top uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .opcode(opcode), .dim_select(dim_select),
    .lower_bound(lower_bound), .upper_bound(upper_bound), .subscript(subscript),
    .done(done), .address(address),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  row_major_address_generator_checker checker_i (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .opcode(opcode), .dim_select(dim_select),
    .lower_bound(lower_bound), .upper_bound(upper_bound), .subscript(subscript),
    .done(done), .address(address),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Present one item beat and hold it until it is taken
  task automatic push_item(input logic op, input logic [SEL_W-1:0] sel,
                           input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                           input logic [DATA_W-1:0] sub);
    start       <= 1'b1;
    opcode      <= op;
    dim_select  <= sel;
    lower_bound <= lo;
    upper_bound <= hi;
    subscript   <= sub;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_bounds(input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] lo,
                             input logic [DATA_W-1:0] hi);
    lower_loaded[sel]  = lo;
    length_loaded[sel] = hi - lo + 1;
    push_item(OP_LOAD, sel, lo, hi, $urandom);
  endtask

  task automatic send_subscript(input logic [DATA_W-1:0] sub);
    push_item(OP_SUB, SEL_W'($urandom), $urandom, $urandom, sub);
  endtask

  // Load random bounds: mostly short ranges, some wide or wrapped ones
  task automatic load_random(input logic [SEL_W-1:0] sel);
    bit [DATA_W-1:0] lo;
    bit [DATA_W-1:0] hi;
    int              kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      lo = $urandom;
      hi = $urandom;
    end else if (kind == 1) begin
      lo = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      hi = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      lo = (kind == 2) ? $urandom : $urandom_range(0, 40) - 20;
      hi = lo + $urandom_range(0, 7);
    end
    load_bounds(sel, lo, hi);
  endtask

  // Drop start for a random number of cycles
  task automatic sender_gap(input int pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every address has come back and the block has settled
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Configure, then run random loads and subscripts
  task automatic run_phase(input logic [31:0] base, input logic [31:0] esize,
                           input logic [31:0] dcount, input int pct, input int count);
    int              d;
    bit [DATA_W-1:0] sub;
    drain();
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_ELEMENT_SIZE, esize);
    write_register(REG_DIMENSION_COUNT, dcount);
    for (int n = 0; n < count; n++) begin
      d = $urandom_range(0, MAX_DIMS - 1);
      if ($urandom_range(0, 3) == 0) begin
        load_random(SEL_W'(d));
      end else begin
        if ($urandom_range(0, 4) != 0 && length_loaded[d] != 0 && length_loaded[d] <= 64)
          sub = lower_loaded[d] + $urandom_range(0, int'(length_loaded[d]) - 1);
        else
          sub = $urandom;
        send_subscript(sub);
      end
      sender_gap(pct);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table: full-range, single and wrapped bounds first
    load_bounds(SEL_W'(0), 32'h8000_0000, 32'h7fff_ffff);
    load_bounds(SEL_W'(1), 32'h0000_0000, 32'h0000_0000);
    load_bounds(SEL_W'(2), 32'h7fff_ffff, 32'h8000_0000);
    for (int d = 3; d < MAX_DIMS; d++) load_random(SEL_W'(d));

    // Single dimension at reset settings, subscript extremes
    send_subscript(32'h8000_0000);
    send_subscript(32'h7fff_ffff);
    send_subscript(32'h0000_0000);

    // Count of zero behaves as one
    drain();
    write_register(REG_DIMENSION_COUNT, 32'd0);
    send_subscript($urandom);

    // Lower the count while an address is half built
    drain();
    write_register(REG_DIMENSION_COUNT, 32'd3);
    send_subscript($urandom);
    send_subscript($urandom);
    drain();
    write_register(REG_DIMENSION_COUNT, 32'd1);
    send_subscript($urandom);

    // Sender idles rarely, then often, then never
    run_phase(32'h0000_1000, 32'd4, 32'd3, 14, 120);
    run_phase($urandom, 32'd65535, 32'd16, 14, 120);
    run_phase(32'h7fff_ffff, 32'd8, 32'd2, 14, 120);
    run_phase(32'h8000_0000, 32'd0, 32'd5, 64, 120);
    run_phase($urandom, $urandom, 32'd31, 64, 120);
    run_phase($urandom, 32'd1, 32'd1, 64, 120);
    run_phase($urandom, $urandom_range(0, 65535), $urandom_range(1, 16), 0, 120);
    run_phase(32'h0000_0000, 32'd2, 32'd4, 0, 120);

    drain();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rmag_pkg.sv
rtl/core/rmag_bound_table.sv
rtl/core/rmag_mul.sv
rtl/core/rmag_ctrl.sv
rtl/core/row_major_address_generator_top.sv
tb/row_major_address_generator_checker.sv
tb/row_major_address_generator_top_test.sv
